/* src/slca_pkg.sv */
// Shared constants, codes and payload types for the serial line command assembler.
package slca_pkg;

	localparam int RING_DEPTH_DEF  = 64;
	localparam int MAX_CMD_LEN_DEF = 16;
	localparam int CMD_LEN_W       = 5;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	localparam logic [1:0] MODE_RX    = 2'd0;
	localparam logic [1:0] MODE_PROC  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]           cmd_byte;
		logic [CMD_LEN_W-1:0] cmd_length;
		logic                 last;
	} result_t;

endpackage

/* src/slca_stream_if.sv */
// Valid/ready stream channel with a typed payload.
interface slca_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/slca_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module slca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/serial_line_command_assembler.sv */
// Serial line command assembler: receive ring, line assembly and command output.
// Items on the item channel either store a received byte in a RING_DEPTH-byte ring,
// clear the indices and assembly state, or take one byte from the ring (the ring
// memory read, then a step that classifies the byte and writes it to the command
// memory). CR or LF ends a nonempty command; a command also ends at MAX_CMD_LEN bytes.
// A finished command is sent on the result channel one byte per transfer, each byte
// going through a command memory read and then the transfer, which waits while the
// result sink holds ready low. No item is taken while a byte is being processed or a
// command is being sent. The ring has no overflow check: when the writer laps the
// reader the ring reads as empty.
module serial_line_command_assembler
	import slca_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int MAX_CMD_LEN = MAX_CMD_LEN_DEF
) (
	input logic        clk,
	input logic        arst_n,
	slca_stream_if.sink   item,
	slca_stream_if.source result
);
	localparam int RW = $clog2(RING_DEPTH);
	localparam int CW = (MAX_CMD_LEN > 1) ? $clog2(MAX_CMD_LEN) : 1;
	localparam int LW = $clog2(MAX_CMD_LEN + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PROC = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]    state_q;
	logic [RW-1:0] wr_idx_q;
	logic [RW-1:0] rd_idx_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] emit_idx_q;
	logic [LW-1:0] len_q;

	logic          item_fire;
	logic          ring_empty;
	logic          ring_we;
	logic          ring_re;
	logic [7:0]    ring_rdata;
	logic          is_eol;
	logic          cmd_we;
	logic          cmd_re;
	logic [7:0]    cmd_rdata;
	logic          emit_last;
	logic [RW-1:0] wr_idx_nxt;
	logic [RW-1:0] rd_idx_nxt;

	assign item.ready = (state_q == ST_IDLE);
	assign item_fire  = item.valid && item.ready;
	assign ring_empty = (wr_idx_q == rd_idx_q);

	assign wr_idx_nxt = (wr_idx_q == RW'(RING_DEPTH - 1)) ? '0 : wr_idx_q + RW'(1);
	assign rd_idx_nxt = (rd_idx_q == RW'(RING_DEPTH - 1)) ? '0 : rd_idx_q + RW'(1);

	assign ring_we = item_fire && (item.payload.mode == MODE_RX);
	assign ring_re = item_fire && (item.payload.mode == MODE_PROC) && !ring_empty;

	slca_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(wr_idx_q),
		.wdata(item.payload.rx_byte),
		.re   (ring_re),
		.raddr(rd_idx_q),
		.rdata(ring_rdata)
	);

	assign is_eol = (ring_rdata == BYTE_CR) || (ring_rdata == BYTE_LF);
	assign cmd_we = (state_q == ST_PROC) && !is_eol;
	assign cmd_re = (state_q == ST_RD);

	slca_ram #(
		.WIDTH(8),
		.DEPTH(MAX_CMD_LEN)
	) u_cmd_ram (
		.clk  (clk),
		.we   (cmd_we),
		.waddr(cnt_q),
		.wdata(ring_rdata),
		.re   (cmd_re),
		.raddr(emit_idx_q),
		.rdata(cmd_rdata)
	);

	// read data stays put until the next read, so it serves as the output register
	assign emit_last                 = ((LW'(emit_idx_q) + LW'(1)) == len_q);
	assign result.valid              = (state_q == ST_OUT);
	assign result.payload.cmd_byte   = cmd_rdata;
	assign result.payload.cmd_length = CMD_LEN_W'(len_q);
	assign result.payload.last       = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			cnt_q      <= '0;
			emit_idx_q <= '0;
			len_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						case (item.payload.mode)
							MODE_RX: begin
								wr_idx_q <= wr_idx_nxt;
							end
							MODE_CLEAR: begin
								wr_idx_q <= '0;
								rd_idx_q <= '0;
								cnt_q    <= '0;
							end
							MODE_PROC: begin
								if (!ring_empty) begin
									rd_idx_q <= rd_idx_nxt;
									state_q  <= ST_PROC;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PROC: begin
					if (is_eol) begin
						if (cnt_q != '0) begin
							len_q      <= LW'(cnt_q);
							cnt_q      <= '0;
							emit_idx_q <= '0;
							state_q    <= ST_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (cnt_q == CW'(MAX_CMD_LEN - 1)) begin
						// full-length command ends without a terminator
						len_q      <= LW'(MAX_CMD_LEN);
						cnt_q      <= '0;
						emit_idx_q <= '0;
						state_q    <= ST_RD;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (result.ready) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + CW'(1);
							state_q    <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* dv/serial_line_command_assembler_test.sv */
// Self-checking testbench for the serial line command assembler: directed and random stream traffic.
`timescale 1ns / 1ps

module serial_line_command_assembler_test;
	import slca_pkg::*;

	localparam int RING_N = RING_DEPTH_DEF;
	localparam int CMD_MAX = MAX_CMD_LEN_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		item_t it;
		bit    hold;
	} stim_t;

	logic clk;
	logic arst_n;

	slca_stream_if #(.payload_t(item_t))   item_ch ();
	slca_stream_if #(.payload_t(result_t)) result_ch ();

	serial_line_command_assembler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor state
	logic [7:0] ring_mem [RING_N];
	logic [7:0] line_buf [CMD_MAX];
	int         wr_ptr;
	int         rd_ptr;
	int         line_len;

	stim_t   stim_q [$];
	result_t expected_cmd_q [$];

	int          err_count;
	int unsigned results_seen;
	int          burst_left;
	int          gap_left;
	int unsigned cyc;
	int unsigned stall_style;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
				results_seen, name, got, want));
	endtask

	task automatic queue_item(logic [1:0] mode, logic [7:0] data, bit hold = 1'b0);
		stim_t s;
		s.it.mode    = mode;
		s.it.rx_byte = data;
		s.hold       = hold;
		stim_q.push_back(s);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == BYTE_CR || b == BYTE_LF);
		return b;
	endfunction

	task automatic emit_line(int len);
		result_t r;
		for (int k = 0; k < len; k++) begin
			r.cmd_byte   = line_buf[k];
			r.cmd_length = CMD_LEN_W'(len);
			r.last       = (k == len - 1);
			expected_cmd_q.push_back(r);
		end
	endtask

	// Advance the line assembler by one accepted item, queueing any finished command.
	task automatic assemble_item(item_t it);
		logic [7:0] b;
		case (it.mode)
			MODE_RX: begin
				ring_mem[wr_ptr] = it.rx_byte;
				wr_ptr = (wr_ptr + 1) % RING_N;
			end
			MODE_CLEAR: begin
				wr_ptr   = 0;
				rd_ptr   = 0;
				line_len = 0;
			end
			MODE_PROC: begin
				if (wr_ptr != rd_ptr) begin
					b = ring_mem[rd_ptr];
					rd_ptr = (rd_ptr + 1) % RING_N;
					if (b == BYTE_CR || b == BYTE_LF) begin
						if (line_len > 0)
							emit_line(line_len);
						line_len = 0;
					end else begin
						line_buf[line_len] = b;
						line_len++;
						if (line_len >= CMD_MAX) begin
							emit_line(CMD_MAX);
							line_len = 0;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// item driver: bursts with random gaps, optional drain before a held item
	always @(posedge clk or negedge arst_n) begin
		logic  send;
		stim_t cur;
		if (!arst_n) begin
			item_ch.valid   <= 1'b0;
			item_ch.payload <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			send = 1'b0;
			if (item_ch.valid && item_ch.ready)
				assemble_item(item_ch.payload);
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() != 0 &&
						!(stim_q[0].hold && expected_cmd_q.size() != 0)) begin
					cur = stim_q.pop_front();
					item_ch.payload <= cur.it;
					send = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				item_ch.valid <= send;
			end
		end
	end

	// result sink: ready follows a stall style that is re-picked at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			cyc = 0;
			stall_style = 0;
		end else begin
			cyc++;
			if (cyc % 150 == 0)
				stall_style = $urandom_range(0, 3);
			case (stall_style)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= (cyc % 9) < 5;
				default: result_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_cmd_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result: byte 0x%0h len %0d last %0b",
					result_ch.payload.cmd_byte, result_ch.payload.cmd_length,
					result_ch.payload.last));
			end else begin
				want = expected_cmd_q.pop_front();
				check_field("cmd_byte", result_ch.payload.cmd_byte, want.cmd_byte);
				check_field("cmd_length", result_ch.payload.cmd_length, want.cmd_length);
				check_field("last", result_ch.payload.last, want.last);
			end
			results_seen++;
		end
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int useful;
		int unread;
		int len;
		int n;
		int pick;
		bit first;
		arst_n          = 1'b0;

		// directed: empty ring, unused mode, extreme bytes, empty line, clear mid-line
		queue_item(MODE_PROC, 8'h5A);
		queue_item(MODE_UNUSED, 8'hFF);
		queue_item(MODE_RX, 8'h00);
		queue_item(MODE_RX, 8'hFF);
		queue_item(MODE_RX, BYTE_CR);
		repeat (3) queue_item(MODE_PROC, 8'h00);
		queue_item(MODE_RX, BYTE_LF);
		queue_item(MODE_PROC, 8'hFF);
		queue_item(MODE_RX, 8'h41);
		queue_item(MODE_PROC, 8'h00);
		queue_item(MODE_CLEAR, 8'hA5);
		queue_item(MODE_RX, BYTE_LF);
		queue_item(MODE_PROC, 8'h00);
		queue_item(MODE_RX, 8'h42);
		queue_item(MODE_RX, BYTE_CR);
		repeat (3) queue_item(MODE_PROC, 8'h00);

		// random: mostly well-formed lines, plus clears, noise, broken runs and overruns
		useful = 0;
		unread = 0;
		first  = 1'b1;
		while (useful < 480) begin
			pick = first ? 99 : $urandom_range(0, 99);
			first = 1'b0;
			if (pick < 70) begin
				n = $urandom_range(0, 19);
				len = (n == 0) ? 0 : (n < 16) ? $urandom_range(1, CMD_MAX - 1)
					: (n < 18) ? CMD_MAX : $urandom_range(CMD_MAX + 1, 40);
				for (int k = 0; k <= len; k++) begin
					if (unread >= 56) begin
						queue_item(MODE_PROC, 8'($urandom));
						unread--;
						useful++;
					end
					queue_item(MODE_RX, (k < len) ? text_byte()
						: ($urandom_range(0, 1) ? BYTE_CR : BYTE_LF));
					unread++;
					useful++;
					if ($urandom_range(0, 1)) begin
						queue_item(MODE_PROC, 8'($urandom));
						unread--;
						useful++;
					end
				end
				if ($urandom_range(0, 4) != 0) begin
					while (unread > 0) begin
						queue_item(MODE_PROC, 8'($urandom));
						unread--;
						useful++;
					end
				end
			end else if (pick < 78) begin
				queue_item(MODE_CLEAR, 8'($urandom));
				unread = 0;
				useful++;
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 2))
						0: queue_item(MODE_UNUSED, 8'($urandom));
						1: begin
							queue_item(MODE_PROC, 8'($urandom));
							if (unread > 0) begin
								unread--;
								useful++;
							end
						end
						default: begin
							if (unread < 60) begin
								queue_item(MODE_RX, 8'($urandom));
								unread++;
								useful++;
							end
						end
					endcase
				end
			end else if (pick < 96) begin
				// broken run: raw bytes, terminators anywhere, partial processing
				n = $urandom_range(1, 8);
				while (unread + n > 60) begin
					queue_item(MODE_PROC, 8'($urandom));
					unread--;
					useful++;
				end
				repeat (n) begin
					queue_item(MODE_RX, ($urandom_range(0, 3) == 0)
						? ($urandom_range(0, 1) ? BYTE_CR : BYTE_LF) : 8'($urandom));
					useful++;
				end
				unread += n;
				repeat ($urandom_range(0, n)) begin
					queue_item(MODE_PROC, 8'($urandom));
					unread--;
					useful++;
				end
			end else begin
				// overrun: lap the reader so unread bytes vanish
				n = RING_N + $urandom_range(0, 5);
				for (int k = 0; k < n; k++) begin
					queue_item(MODE_RX, text_byte(), k == 0);
					useful++;
				end
				unread = (unread + n) % RING_N;
				while (unread > 0) begin
					queue_item(MODE_PROC, 8'($urandom));
					unread--;
					useful++;
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (expected_cmd_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (expected_cmd_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_cmd_q.size()));

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
